@@ hw/rtl/assert_macros.svh @@
// Assertion helpers; all checks are sampled on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ hw/rtl/hlfc_pkg.sv @@
`timescale 1ns / 1ps
package hlfc_pkg;

  localparam int AngleStepsDef = 1024;
  localparam int FracBitsDef   = 4;

  localparam int AngleW  = 10;
  localparam int RhoW    = 18;
  localparam int DimW    = 12;
  localparam int TrigW   = 16;   // Q1.15 signed
  localparam int MagW    = 15;   // magnitude of a Q1.15 value
  localparam int CoordW  = 16;
  localparam int CountW  = 3;
  localparam int CfgIdxW = 2;
  localparam int NumEdge = 4;

  localparam logic [DimW-1:0] WidthRst  = 12'd640;
  localparam logic [DimW-1:0] HeightRst = 12'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] count;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [CoordW-1:0] ex;
    logic [CoordW-1:0] ey;
  } result_t;

  localparam logic [63:0] PiQ30  = 64'd3373259426;
  localparam logic [63:0] OneQ30 = 64'd1 << 30;

  // First-quadrant sine, Taylor series in Horner form, Q1.15 result.
  function automatic logic [TrigW-1:0] quarter_sine(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (a * PiQ30) >> 16;
    x2 = (x * x) >> 30;
    t  = OneQ30 - x2 / 64'd110;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd72;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd42;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd20;
    t  = OneQ30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[TrigW-1:0];
  endfunction

  // Sine of a phase in units of pi/65536, folded to the first quadrant.
  function automatic logic signed [TrigW-1:0] phase_sine(input logic [31:0] u);
    logic [31:0] uu;
    logic [31:0] v;
    logic [31:0] a;
    logic        neg;
    logic [TrigW-1:0] s;
    uu  = u & 32'h1FFFF;
    neg = (uu >= 32'd65536);
    v   = neg ? (uu - 32'd65536) : uu;
    a   = (v <= 32'd32768) ? v : (32'd65536 - v);
    s   = quarter_sine({32'd0, a});
    return neg ? $signed(-s) : $signed(s);
  endfunction

endpackage

@@ hw/rtl/hlfc_trig.sv @@
`timescale 1ns / 1ps
module hlfc_trig #(
  parameter int ANGLE_STEPS = hlfc_pkg::AngleStepsDef
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [hlfc_pkg::AngleW-1:0]       angle_i,
  input  logic signed [hlfc_pkg::RhoW-1:0]  rho_i,
  output logic signed [hlfc_pkg::TrigW-1:0] sin_o,
  output logic signed [hlfc_pkg::TrigW-1:0] cos_o,
  output logic signed [hlfc_pkg::RhoW-1:0]  rho_o
);
  import hlfc_pkg::*;

  localparam int NumAngles = 2 ** AngleW;

  logic signed [TrigW-1:0] sin_lut [NumAngles];
  logic signed [TrigW-1:0] cos_lut [NumAngles];
  logic signed [TrigW-1:0] sin_q, cos_q;
  logic signed [RhoW-1:0]  rho_q;

  // Constant sine/cosine tables over every angle code
  for (genvar i = 0; i < NumAngles; i++) begin : g_lut
    localparam longint P = longint'(i) % (2 * ANGLE_STEPS);
    localparam longint U = ((P << 16) + ANGLE_STEPS / 2) / ANGLE_STEPS;
    assign sin_lut[i] = phase_sine(32'(U));
    assign cos_lut[i] = phase_sine(32'(U + 32768));
  end

  // Stage 0: table read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_lut[angle_i];
      cos_q <= cos_lut[angle_i];
      rho_q <= rho_i;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
  assign rho_o = rho_q;

endmodule

@@ hw/rtl/hlfc_edge.sv @@
`timescale 1ns / 1ps
module hlfc_edge #(
  parameter int FRAC_BITS = hlfc_pkg::FracBitsDef,
  localparam int LW = hlfc_pkg::DimW + FRAC_BITS,
  localparam int RW = LW + hlfc_pkg::MagW
) (
  input  logic                                              clk_i,
  input  logic                                              en_i,
  input  logic signed [hlfc_pkg::TrigW-1:0]                 sin_i,
  input  logic signed [hlfc_pkg::TrigW-1:0]                 cos_i,
  input  logic signed [hlfc_pkg::RhoW-1:0]                  rho_i,
  input  logic [hlfc_pkg::DimW-1:0]                         width_i,
  input  logic [hlfc_pkg::DimW-1:0]                         height_i,
  output logic [hlfc_pkg::NumEdge-1:0]                      hit_o,
  output logic [hlfc_pkg::NumEdge-1:0][RW-1:0]              dvd_o,
  output logic [hlfc_pkg::NumEdge-1:0][hlfc_pkg::MagW-1:0]  dvs_o
);
  import hlfc_pkg::*;

  localparam int PW = LW + TrigW + 1;                  // dim times signed trig
  localparam int NW = ((PW > RhoW + 15) ? PW : RhoW + 15) + 1;

  logic [LW-1:0]           w_lim, h_lim;
  logic signed [NW-1:0]    rho_s;
  logic signed [PW-1:0]    hs_prod, wc_prod;
  logic [MagW-1:0]         cmag, smag;

  logic signed [NW-1:0]    num_d [NumEdge];
  logic                    neg_d [NumEdge];
  logic [MagW-1:0]         mag_d [NumEdge];
  logic [RW-1:0]           lim_d [NumEdge];
  logic                    gate_d [NumEdge];

  logic signed [NW-1:0]    num_q [NumEdge];
  logic                    neg_q [NumEdge];
  logic [MagW-1:0]         mag_q [NumEdge];
  logic [RW-1:0]           lim_q [NumEdge];
  logic                    gate_q [NumEdge];

  logic signed [NW:0]      nrm [NumEdge];
  logic [NumEdge-1:0]      hit_d, hit_q;
  logic [RW-1:0]           dvd_d [NumEdge];
  logic [RW-1:0]           dvd_q [NumEdge];
  logic [MagW-1:0]         dvs_q [NumEdge];

  // Stage 1: numerators, divisor magnitudes and edge limits
  always_comb begin
    w_lim   = LW'(width_i) << FRAC_BITS;
    h_lim   = LW'(height_i) << FRAC_BITS;
    rho_s   = NW'(rho_i) <<< 15;
    hs_prod = $signed({1'b0, h_lim}) * sin_i;
    wc_prod = $signed({1'b0, w_lim}) * cos_i;
    cmag    = cos_i[TrigW-1] ? MagW'(-cos_i) : MagW'(cos_i);
    smag    = sin_i[TrigW-1] ? MagW'(-sin_i) : MagW'(sin_i);

    num_d[0] = rho_s - NW'(hs_prod);   // top
    num_d[1] = rho_s;                  // bottom
    num_d[2] = rho_s;                  // left
    num_d[3] = rho_s - NW'(wc_prod);   // right
    neg_d[0] = cos_i[TrigW-1];
    neg_d[1] = cos_i[TrigW-1];
    neg_d[2] = sin_i[TrigW-1];
    neg_d[3] = sin_i[TrigW-1];
    mag_d[0] = cmag;
    mag_d[1] = cmag;
    mag_d[2] = smag;
    mag_d[3] = smag;
    lim_d[0] = RW'(w_lim) * RW'(cmag);
    lim_d[1] = lim_d[0];
    lim_d[2] = RW'(h_lim) * RW'(smag);
    lim_d[3] = lim_d[2];
    gate_d[0] = (cos_i != '0);
    gate_d[1] = (cos_i != '0);
    gate_d[2] = (sin_i != '0);
    gate_d[3] = (sin_i != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int e = 0; e < NumEdge; e++) begin
        num_q[e]  <= num_d[e];
        neg_q[e]  <= neg_d[e];
        mag_q[e]  <= mag_d[e];
        lim_q[e]  <= lim_d[e];
        gate_q[e] <= gate_d[e];
      end
    end
  end

  // Stage 2: sign fold, strict interior test, rounding offset
  always_comb begin
    for (int e = 0; e < NumEdge; e++) begin
      nrm[e]   = neg_q[e] ? -(NW+1)'(num_q[e]) : (NW+1)'(num_q[e]);
      hit_d[e] = gate_q[e] && (nrm[e] > 0) && (nrm[e] < $signed((NW+1)'(lim_q[e])));
      dvd_d[e] = nrm[e][RW-1:0] + RW'(mag_q[e] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
      for (int e = 0; e < NumEdge; e++) begin
        dvd_q[e] <= dvd_d[e];
        dvs_q[e] <= mag_q[e];
      end
    end
  end

  always_comb begin
    hit_o = hit_q;
    for (int e = 0; e < NumEdge; e++) begin
      dvd_o[e] = dvd_q[e];
      dvs_o[e] = dvs_q[e];
    end
  end

endmodule

@@ hw/rtl/hlfc_div.sv @@
`timescale 1ns / 1ps
module hlfc_div #(
  parameter int FRAC_BITS = hlfc_pkg::FracBitsDef,
  localparam int QW = hlfc_pkg::DimW + FRAC_BITS,
  localparam int RW = QW + hlfc_pkg::MagW
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      hit_i,
  input  logic [RW-1:0]             dvd_i,
  input  logic [hlfc_pkg::MagW-1:0] dvs_i,
  output logic                      hit_o,
  output logic [QW-1:0]             quo_o
);
  import hlfc_pkg::*;

  logic [RW-1:0]   rem_q [QW];
  logic [MagW-1:0] dvs_q [QW];
  logic [QW-1:0]   quo_q [QW];
  logic            hit_q [QW];

  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int Bit = QW - 1 - s;
    logic [RW-1:0]   rem_in, shf;
    logic [MagW-1:0] dvs_in;
    logic [QW-1:0]   quo_in;
    logic            hit_in, take;

    if (s == 0) begin : g_first
      assign rem_in = dvd_i;
      assign dvs_in = dvs_i;
      assign quo_in = '0;
      assign hit_in = hit_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dvs_in = dvs_q[s-1];
      assign quo_in = quo_q[s-1];
      assign hit_in = hit_q[s-1];
    end

    assign shf  = RW'(dvs_in) << Bit;
    assign take = (rem_in >= shf);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? (rem_in - shf) : rem_in;
        dvs_q[s] <= dvs_in;
        quo_q[s] <= {quo_in[QW-2:0], take};
        hit_q[s] <= hit_in;
      end
    end
  end

  assign hit_o = hit_q[QW-1];
  assign quo_o = quo_q[QW-1];

endmodule

@@ hw/rtl/hlfc_pack.sv @@
`timescale 1ns / 1ps
module hlfc_pack #(
  parameter int FRAC_BITS = hlfc_pkg::FracBitsDef,
  localparam int QW = hlfc_pkg::DimW + FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [hlfc_pkg::NumEdge-1:0]         hit_i,
  input  logic [hlfc_pkg::NumEdge-1:0][QW-1:0] quo_i,
  input  logic [hlfc_pkg::DimW-1:0]            width_i,
  input  logic [hlfc_pkg::DimW-1:0]            height_i,
  input  logic                                 out_stall_i,
  output logic                                 skid_full_o,
  output logic                                 out_valid_o,
  output hlfc_pkg::result_t                    res_o
);
  import hlfc_pkg::*;

  logic [CoordW-1:0] x_c [NumEdge];
  logic [CoordW-1:0] y_c [NumEdge];
  logic [CountW-1:0] cnt;
  result_t           res_d;
  result_t           pipe_res_q, skid_res_q;
  logic              pipe_valid_q, skid_valid_q;
  logic              en;

  function automatic logic [CoordW-1:0] sat_coord(input logic [QW-1:0] v);
    logic [31:0] ve;
    ve = 32'(v);
    return ((ve >> CoordW) != '0) ? '1 : ve[CoordW-1:0];
  endfunction

  // Edge coordinates and first-two selection
  always_comb begin
    x_c[0] = sat_coord(quo_i[0]);
    y_c[0] = sat_coord(QW'(height_i) << FRAC_BITS);
    x_c[1] = sat_coord(quo_i[1]);
    y_c[1] = '0;
    x_c[2] = '0;
    y_c[2] = sat_coord(quo_i[2]);
    x_c[3] = sat_coord(QW'(width_i) << FRAC_BITS);
    y_c[3] = sat_coord(quo_i[3]);

    res_d = '0;
    cnt   = '0;
    for (int e = 0; e < NumEdge; e++) begin
      if (hit_i[e]) begin
        if (cnt == 3'd0) begin
          res_d.sx = x_c[e];
          res_d.sy = y_c[e];
        end else if (cnt == 3'd1) begin
          res_d.ex = x_c[e];
          res_d.ey = y_c[e];
        end
        cnt = cnt + 3'd1;
      end
    end
    res_d.count = cnt;
    res_d.found = (cnt == 3'd2);
    if (!res_d.found) begin
      res_d.sx = '0;
      res_d.sy = '0;
      res_d.ex = '0;
      res_d.ey = '0;
    end
  end

  assign en = !skid_valid_q;

  // Output stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else if (en) begin
      pipe_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pipe_res_q <= res_d;
  end

  // Skid register catches the result when the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      skid_valid_q <= pipe_valid_q && out_stall_i;
    end else if (!out_stall_i) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) skid_res_q <= pipe_res_q;
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = skid_valid_q || pipe_valid_q;
  assign res_o       = skid_valid_q ? skid_res_q : pipe_res_q;

endmodule

@@ hw/rtl/hough_line_frame_clip_top.sv @@
`timescale 1ns / 1ps
// Hough line to frame segment clipper. Takes one line (angle code, signed
// distance with FRAC_BITS fraction bits) per cycle while in_stall_o is low
// and returns one result per line: the count of strictly interior
// crossings with the frame edges (top, bottom, left, right in that order)
// and, when the count is two, the two crossings as segment endpoints. The
// pipeline is the table read, the edge-setup stages (numerators, then
// sign fold and interior test), the bit-per-stage restoring dividers (one
// per edge) and the output register. A skid register on the output lets
// one result wait; in_stall_o rises only while it is occupied. Frame width
// and height are written through the cfg port and reset to 640 by 480; the
// user must write them only while idle, which the block does not enforce.
`include "assert_macros.svh"
module hough_line_frame_clip_top #(
  parameter int ANGLE_STEPS = hlfc_pkg::AngleStepsDef,
  parameter int FRAC_BITS   = hlfc_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hlfc_pkg::AngleW-1:0]        line_angle_i,
  input  logic signed [hlfc_pkg::RhoW-1:0]   line_distance_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               segment_found_o,
  output logic [hlfc_pkg::CountW-1:0]        crossing_count_o,
  output logic [hlfc_pkg::CoordW-1:0]        start_x_o,
  output logic [hlfc_pkg::CoordW-1:0]        start_y_o,
  output logic [hlfc_pkg::CoordW-1:0]        end_x_o,
  output logic [hlfc_pkg::CoordW-1:0]        end_y_o,
  input  logic                               cfg_we_i,
  input  logic [hlfc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hlfc_pkg::DimW-1:0]          cfg_data_i
);
  import hlfc_pkg::*;

  localparam int QW = DimW + FRAC_BITS;
  localparam int RW = QW + MagW;
  localparam int NV = 3 + QW;          // stages ahead of the output stage

  logic [DimW-1:0]            width_q, height_q;
  logic [NV-1:0]              v_q;
  logic                       en, skid_full;
  logic signed [TrigW-1:0]    sin_w, cos_w;
  logic signed [RhoW-1:0]     rho_w;
  logic [NumEdge-1:0]         hit_e, hit_dv;
  logic [NumEdge-1:0][RW-1:0] dvd_e;
  logic [NumEdge-1:0][MagW-1:0] dvs_e;
  logic [NumEdge-1:0][QW-1:0] quo_dv;
  result_t                    res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output skid is occupied
  assign en         = !skid_full;
  assign in_stall_o = skid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], in_valid_i};
    end
  end

  hlfc_trig #(.ANGLE_STEPS(ANGLE_STEPS)) u_trig (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(line_angle_i),
    .rho_i  (line_distance_i),
    .sin_o  (sin_w),
    .cos_o  (cos_w),
    .rho_o  (rho_w)
  );

  hlfc_edge #(.FRAC_BITS(FRAC_BITS)) u_edge (
    .clk_i   (clk_i),
    .en_i    (en),
    .sin_i   (sin_w),
    .cos_i   (cos_w),
    .rho_i   (rho_w),
    .width_i (width_q),
    .height_i(height_q),
    .hit_o   (hit_e),
    .dvd_o   (dvd_e),
    .dvs_o   (dvs_e)
  );

  for (genvar e = 0; e < NumEdge; e++) begin : g_div
    hlfc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .hit_i(hit_e[e]),
      .dvd_i(dvd_e[e]),
      .dvs_i(dvs_e[e]),
      .hit_o(hit_dv[e]),
      .quo_o(quo_dv[e])
    );
  end

  hlfc_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v_q[NV-1]),
    .hit_i      (hit_dv),
    .quo_i      (quo_dv),
    .width_i    (width_q),
    .height_i   (height_q),
    .out_stall_i(out_stall_i),
    .skid_full_o(skid_full),
    .out_valid_o(out_valid_o),
    .res_o      (res)
  );

  assign segment_found_o  = res.found;
  assign crossing_count_o = res.count;
  assign start_x_o        = res.sx;
  assign start_y_o        = res.sy;
  assign end_x_o          = res.ex;
  assign end_y_o          = res.ey;

  // Checks
  `ASSERT_CLK(a_skid_implies_valid, in_stall_o |-> out_valid_o)
  `ASSERT_CLK(a_found_matches_count,
              out_valid_o |-> (segment_found_o == (crossing_count_o == 3'd2)))
  `ASSERT_CLK(a_no_segment_zero,
              (out_valid_o && !segment_found_o) |->
              (start_x_o == '0 && start_y_o == '0 && end_x_o == '0 && end_y_o == '0))
  `ASSERT_NEVER(a_count_range, out_valid_o && (crossing_count_o > 3'd4))

endmodule
